@@ design/rectangle_grid_color_pattern_assert.svh @@
// Assertion macros used by the rectangle grid color pattern top level.
`ifndef RECTANGLE_GRID_COLOR_PATTERN_ASSERT_SVH
`define RECTANGLE_GRID_COLOR_PATTERN_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted.
`define RGCP_ASSERT_IMP(name, clk_sig, rstn_sig, ante, cons) \
    name: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |-> (cons)) \
        else $error("rgcp: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define RGCP_ASSERT_NEXT(name, clk_sig, rstn_sig, ante, cons) \
    name: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |=> (cons)) \
        else $error("rgcp: next-cycle check failed");

`else

`define RGCP_ASSERT_IMP(name, clk_sig, rstn_sig, ante, cons)
`define RGCP_ASSERT_NEXT(name, clk_sig, rstn_sig, ante, cons)

`endif

`endif

@@ design/rgcp_pkg.sv @@
// Types, constants and helper functions of the rectangle grid color pattern.
`timescale 1ns / 1ps

package rgcp_pkg;

    // Field widths.
    localparam int unsigned COORD_W        = 12;
    localparam int unsigned COUNT_W        = 8;
    localparam int unsigned COLOR_W        = 32;
    localparam int unsigned STEP_W         = 8;
    localparam int unsigned SIZES_W        = 12;
    localparam int unsigned POS_W          = 15;
    localparam int unsigned CFG_DATA_W     = 32;
    localparam int unsigned CFG_INDEX_W    = 3;
    localparam int unsigned INDEX_BITS_DEF = 8;

    // Restoring division: quotient bits resolved per pipeline stage.
    localparam int unsigned DIV_STEP_BITS  = 3;
    localparam int unsigned DIV_STAGES     = COORD_W / DIV_STEP_BITS;
    localparam int unsigned GRID_STAGES    = 2 * DIV_STAGES;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_INDEXED_MODE    = 3'd0,
        REG_RECT_COUNT      = 3'd1,
        REG_FIRST_COLOR     = 3'd2,
        REG_COLOR_STEP      = 3'd3,
        REG_HORIZ_RES       = 3'd4,
        REG_VERT_RES        = 3'd5,
        REG_FIELD_SIZES     = 3'd6,
        REG_FIELD_POSITIONS = 3'd7
    } cfg_idx_t;

    // Configuration register file contents.
    typedef struct packed {
        logic               indexed_mode;
        logic [COUNT_W-1:0] rect_count;
        logic [COLOR_W-1:0] first_color;
        logic [STEP_W-1:0]  color_step;
        logic [COORD_W-1:0] horiz_res;
        logic [COORD_W-1:0] vert_res;
        logic [SIZES_W-1:0] field_sizes;
        logic [POS_W-1:0]   field_positions;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        indexed_mode:    1'b1,
        rect_count:      8'd1,
        first_color:     32'd0,
        color_step:      8'd0,
        horiz_res:       12'd1024,
        vert_res:        12'd768,
        field_sizes:     12'd0,
        field_positions: 15'd0
    };

    // Partial remainder and combined dividend/quotient shift register.
    typedef struct packed {
        logic [COORD_W-1:0] rem;
        logic [COORD_W-1:0] dq;
    } div_st_t;

    // Grid column and row of one pixel, handed to the color stages.
    typedef struct packed {
        logic [COUNT_W-1:0] col;
        logic [COUNT_W-1:0] row;
        logic               covered;
    } grid_res_t;

    // A few restoring division steps; a zero divisor yields an all-ones quotient.
    function automatic div_st_t div_steps(input div_st_t st, input logic [COORD_W-1:0] dvsr);
        div_st_t          r;
        logic [COORD_W:0] t;
        r = st;
        t = '0;
        for (int k = 0; k < DIV_STEP_BITS; k++)
        begin
            t    = {r.rem, r.dq[COORD_W-1]};
            r.dq = {r.dq[COORD_W-2:0], 1'b0};
            if (t >= {1'b0, dvsr})
            begin
                t       = t - {1'b0, dvsr};
                r.dq[0] = 1'b1;
            end
            r.rem = t[COORD_W-1:0];
        end
        return r;
    endfunction

endpackage

@@ design/rgcp_grid_pipe.sv @@
// Pipelined divisions that turn a pixel coordinate into its grid column and row.
`timescale 1ns / 1ps

module rgcp_grid_pipe (
    input  logic                        clk,
    input  logic                        rst_n,
    input  rgcp_pkg::cfg_t              cfg,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [rgcp_pkg::COORD_W-1:0] pixel_x,
    input  logic [rgcp_pkg::COORD_W-1:0] pixel_y,
    output logic                        out_valid,
    input  logic                        out_ready,
    output rgcp_pkg::grid_res_t         res
);
    import rgcp_pkg::*;

    // Per-stage payload: coordinates, cell size and both running divisions.
    typedef struct packed {
        logic [COORD_W-1:0] px;
        logic [COORD_W-1:0] py;
        logic [COORD_W-1:0] wid;
        logic [COORD_W-1:0] hgt;
        div_st_t            dvx;
        div_st_t            dvy;
    } grid_st_t;

    grid_st_t                 st_reg  [GRID_STAGES];
    grid_st_t                 st_next [GRID_STAGES];
    grid_st_t                 st_src  [GRID_STAGES];
    logic [GRID_STAGES-1:0]   valid_reg;
    logic [GRID_STAGES-1:0]   valid_src;
    logic [GRID_STAGES:0]     rdy;
    logic [COORD_W-1:0]       count_ext;
    logic [COORD_W-1:0]       col;
    logic [COORD_W-1:0]       row;

    assign count_ext = COORD_W'(cfg.rect_count);

    // A stage takes new data when it is empty or its successor takes its contents.
    always_comb
    begin
        rdy[GRID_STAGES] = out_ready;
        for (int i = GRID_STAGES - 1; i >= 0; i--)
        begin
            rdy[i] = !valid_reg[i] || rdy[i+1];
        end
    end

    assign in_ready  = rdy[0];
    assign valid_src = {valid_reg[GRID_STAGES-2:0], in_valid};

    // Stage logic: the first half divides the resolutions by the rectangle count,
    // the second half divides the coordinates by the resulting cell size.
    always_comb
    begin
        st_src[0].px  = pixel_x;
        st_src[0].py  = pixel_y;
        st_src[0].wid = '0;
        st_src[0].hgt = '0;
        st_src[0].dvx = '{rem: '0, dq: cfg.horiz_res};
        st_src[0].dvy = '{rem: '0, dq: cfg.vert_res};
        for (int i = 1; i < GRID_STAGES; i++)
        begin
            st_src[i] = st_reg[i-1];
        end
        for (int i = 0; i < GRID_STAGES; i++)
        begin
            st_next[i] = st_src[i];
            if (i == DIV_STAGES)
            begin
                st_next[i].wid = st_src[i].dvx.dq;
                st_next[i].hgt = st_src[i].dvy.dq;
                st_next[i].dvx = '{rem: '0, dq: st_src[i].px};
                st_next[i].dvy = '{rem: '0, dq: st_src[i].py};
            end
            if (i < DIV_STAGES)
            begin
                st_next[i].dvx = div_steps(st_next[i].dvx, count_ext);
                st_next[i].dvy = div_steps(st_next[i].dvy, count_ext);
            end
            else
            begin
                st_next[i].dvx = div_steps(st_next[i].dvx, st_next[i].wid);
                st_next[i].dvy = div_steps(st_next[i].dvy, st_next[i].hgt);
            end
        end
    end

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < GRID_STAGES; i++)
            begin
                if (rdy[i])
                begin
                    valid_reg[i] <= valid_src[i];
                end
            end
        end
    end

    // Stage payload.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < GRID_STAGES; i++)
        begin
            if (rdy[i])
            begin
                st_reg[i] <= st_next[i];
            end
        end
    end

    // A zero rectangle count or a zero cell size gives an all-ones quotient,
    // which is never below the count, so the range check covers those cases.
    assign col         = st_reg[GRID_STAGES-1].dvx.dq;
    assign row         = st_reg[GRID_STAGES-1].dvy.dq;
    assign res.col     = col[COUNT_W-1:0];
    assign res.row     = row[COUNT_W-1:0];
    assign res.covered = (col < count_ext) && (row < count_ext);
    assign out_valid   = valid_reg[GRID_STAGES-1];

endmodule

@@ design/rgcp_color_pipe.sv @@
// Color stages: grid products, component wrap and final packing into the output register.
`timescale 1ns / 1ps

module rgcp_color_pipe #(
    parameter int unsigned INDEX_BITS = rgcp_pkg::INDEX_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  rgcp_pkg::cfg_t               cfg,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  rgcp_pkg::grid_res_t          res,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [rgcp_pkg::COLOR_W-1:0] pixel_color,
    output logic                         covered
);
    import rgcp_pkg::*;

    localparam int unsigned PROD_W = INDEX_BITS + STEP_W;

    // Field mask for a component size, sizes above eight saturate.
    function automatic logic [7:0] comp_mask(input logic [3:0] sz);
        logic [3:0] s;
        logic [8:0] m;
        s = (sz > 4'd8) ? 4'd8 : sz;
        m = (9'd1 << s) - 9'd1;
        return m[7:0];
    endfunction

    // Stage A registers.
    logic                  a_valid_reg;
    logic                  a_cov_reg;
    logic [INDEX_BITS-1:0] a_lin_reg;
    logic [7:0]            a_red_add_reg;
    logic [7:0]            a_grn_add_reg;
    logic [7:0]            a_blu_add_reg;
    // Stage B registers.
    logic                  b_valid_reg;
    logic                  b_cov_reg;
    logic [INDEX_BITS-1:0] b_idx_reg;
    logic [7:0]            b_red_reg;
    logic [7:0]            b_grn_reg;
    logic [7:0]            b_blu_reg;
    // Output registers.
    logic                  c_valid_reg;
    logic                  c_cov_reg;
    logic [COLOR_W-1:0]    c_color_reg;

    logic                  a_rdy;
    logic                  b_rdy;
    logic                  c_rdy;

    logic [15:0]           row_times_count;
    logic [16:0]           lin_full;
    logic [15:0]           red_prod;
    logic [15:0]           grn_prod;
    logic [15:0]           blu_prod;
    logic [7:0]            col_plus_row;
    logic [INDEX_BITS-1:0] a_lin_next;

    logic [PROD_W-1:0]     idx_prod;
    logic [COLOR_W-1:0]    red_src;
    logic [COLOR_W-1:0]    grn_src;
    logic [COLOR_W-1:0]    blu_src;
    logic [7:0]            red_sum;
    logic [7:0]            grn_sum;
    logic [7:0]            blu_sum;
    logic [INDEX_BITS-1:0] b_idx_next;
    logic [7:0]            b_red_next;
    logic [7:0]            b_grn_next;
    logic [7:0]            b_blu_next;

    logic [4:0]            red_pos;
    logic [4:0]            grn_pos;
    logic [4:0]            blu_pos;
    logic [INDEX_BITS-1:0] idx_color;
    logic [COLOR_W-1:0]    direct_color;
    logic [COLOR_W-1:0]    c_color_next;

    // Backpressure chain through the three stages.
    assign c_rdy    = !c_valid_reg || out_ready;
    assign b_rdy    = !b_valid_reg || c_rdy;
    assign a_rdy    = !a_valid_reg || b_rdy;
    assign in_ready = a_rdy;

    assign red_pos = cfg.field_positions[4:0];
    assign grn_pos = cfg.field_positions[9:5];
    assign blu_pos = cfg.field_positions[14:10];

    // Stage A: linear rectangle index and per-component increments.
    always_comb
    begin
        row_times_count = 16'(res.row) * 16'(cfg.rect_count);
        lin_full        = 17'(row_times_count) + 17'(res.col);
        a_lin_next      = lin_full[INDEX_BITS-1:0];
        col_plus_row    = res.col + res.row;
        red_prod        = 16'(res.col) * 16'(cfg.color_step);
        grn_prod        = 16'(res.row) * 16'(cfg.color_step);
        blu_prod        = 16'(col_plus_row) * 16'(cfg.color_step);
    end

    // Stage B: indexed product and wrapped direct components.
    always_comb
    begin
        idx_prod   = PROD_W'(a_lin_reg) * PROD_W'(cfg.color_step);
        b_idx_next = idx_prod[INDEX_BITS-1:0];
        red_src    = cfg.first_color >> red_pos;
        grn_src    = cfg.first_color >> grn_pos;
        blu_src    = cfg.first_color >> blu_pos;
        red_sum    = red_src[7:0] + a_red_add_reg;
        grn_sum    = grn_src[7:0] + a_grn_add_reg;
        blu_sum    = blu_src[7:0] + a_blu_add_reg;
        b_red_next = red_sum & comp_mask(cfg.field_sizes[3:0]);
        b_grn_next = grn_sum & comp_mask(cfg.field_sizes[7:4]);
        b_blu_next = blu_sum & comp_mask(cfg.field_sizes[11:8]);
    end

    // Output stage: pick the mode and clear pixels outside the grid.
    always_comb
    begin
        idx_color    = cfg.first_color[INDEX_BITS-1:0] + b_idx_reg;
        direct_color = (COLOR_W'(b_red_reg) << red_pos)
                     | (COLOR_W'(b_grn_reg) << grn_pos)
                     | (COLOR_W'(b_blu_reg) << blu_pos);
        if (!b_cov_reg)
        begin
            c_color_next = '0;
        end
        else if (cfg.indexed_mode)
        begin
            c_color_next = COLOR_W'(idx_color);
        end
        else
        begin
            c_color_next = direct_color;
        end
    end

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_rdy)
            begin
                a_valid_reg <= in_valid;
            end
            if (b_rdy)
            begin
                b_valid_reg <= a_valid_reg;
            end
            if (c_rdy)
            begin
                c_valid_reg <= b_valid_reg;
            end
        end
    end

    // Stage payload.
    always_ff @(posedge clk)
    begin
        if (a_rdy)
        begin
            a_cov_reg     <= res.covered;
            a_lin_reg     <= a_lin_next;
            a_red_add_reg <= red_prod[7:0];
            a_grn_add_reg <= grn_prod[7:0];
            a_blu_add_reg <= blu_prod[7:0];
        end
        if (b_rdy)
        begin
            b_cov_reg <= a_cov_reg;
            b_idx_reg <= b_idx_next;
            b_red_reg <= b_red_next;
            b_grn_reg <= b_grn_next;
            b_blu_reg <= b_blu_next;
        end
        if (c_rdy)
        begin
            c_cov_reg   <= b_cov_reg;
            c_color_reg <= c_color_next;
        end
    end

    assign out_valid   = c_valid_reg;
    assign pixel_color = c_color_reg;
    assign covered     = c_cov_reg;

endmodule

@@ design/rectangle_grid_color_pattern.sv @@
// Top level of the rectangle grid color pattern generator.
// An accepted input passes 8 division stages resolving 3 quotient bits each, then 3 color
// stages including the output register. Throughput: one pixel per cycle while m_axis_tready
// is high; every stage stalls independently, so bubbles collapse.
// Reset clears all valid bits and loads the register defaults; no clearing pass is needed.
`timescale 1ns / 1ps

module rectangle_grid_color_pattern #(
    parameter int unsigned INDEX_BITS = rgcp_pkg::INDEX_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // Configuration write port.
    input  logic                            cfg_we,
    input  logic [rgcp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [rgcp_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    // Pixel coordinates in.
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [23:0]                     s_axis_tdata,  // pixel_x [11:0], pixel_y [23:12]
    // Pattern colors out.
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [31:0]                     m_axis_tdata,  // pixel_color [31:0]
    output logic [0:0]                      m_axis_tuser   // covered [0]
);
    import rgcp_pkg::*;

    `include "rectangle_grid_color_pattern_assert.svh"

    cfg_t      cfg_reg;
    cfg_t      cfg_next;
    logic      grid_valid;
    logic      grid_ready;
    grid_res_t grid_res;
    logic      covered;

    // Register write decode.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_INDEXED_MODE:    cfg_next.indexed_mode    = cfg_wdata[0];
                REG_RECT_COUNT:      cfg_next.rect_count      = cfg_wdata[COUNT_W-1:0];
                REG_FIRST_COLOR:     cfg_next.first_color     = cfg_wdata[COLOR_W-1:0];
                REG_COLOR_STEP:      cfg_next.color_step      = cfg_wdata[STEP_W-1:0];
                REG_HORIZ_RES:       cfg_next.horiz_res       = cfg_wdata[COORD_W-1:0];
                REG_VERT_RES:        cfg_next.vert_res        = cfg_wdata[COORD_W-1:0];
                REG_FIELD_SIZES:     cfg_next.field_sizes     = cfg_wdata[SIZES_W-1:0];
                REG_FIELD_POSITIONS: cfg_next.field_positions = cfg_wdata[POS_W-1:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Column and row lookup.
    rgcp_grid_pipe u_grid (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .pixel_x   (s_axis_tdata[11:0]),
        .pixel_y   (s_axis_tdata[23:12]),
        .out_valid (grid_valid),
        .out_ready (grid_ready),
        .res       (grid_res)
    );

    // Color computation and output register.
    rgcp_color_pipe #(
        .INDEX_BITS (INDEX_BITS)
    ) u_color (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .in_valid    (grid_valid),
        .in_ready    (grid_ready),
        .res         (grid_res),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .pixel_color (m_axis_tdata),
        .covered     (covered)
    );

    assign m_axis_tuser = covered;

    // A pixel outside the grid always carries a zero color.
    `RGCP_ASSERT_IMP(a_uncovered_black, clk, rst_n, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata == 32'd0)
    // The input side only stalls when the division stages are full and blocked.
    `RGCP_ASSERT_IMP(a_in_stall_cause, clk, rst_n, !s_axis_tready, grid_valid && !grid_ready)
    // The color stages only refuse a transaction when the output is held.
    `RGCP_ASSERT_IMP(a_mid_stall_cause, clk, rst_n, !grid_ready, m_axis_tvalid && !m_axis_tready)
    // A blocked internal transaction is not dropped.
    `RGCP_ASSERT_NEXT(a_mid_hold, clk, rst_n, grid_valid && !grid_ready, grid_valid)

endmodule
